### rtl/core/hidkb_pkg.sv
// Shared types and constants of the HID keyboard report tracker.
package hidkb_pkg;

	localparam int SLOT_COUNT  = 6;
	localparam int TABLE_DEPTH = 6;
	localparam int SLOT_LIMIT  = (SLOT_COUNT > TABLE_DEPTH) ? TABLE_DEPTH : SLOT_COUNT;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [7:0] ROLLOVER_CODE = 8'h01;
	localparam logic [7:0] MOD_FIRST     = 8'hE0;
	localparam logic [7:0] MOD_LAST      = 8'hE7;

	localparam logic [1:0] FUNC_KEY   = 2'd0;
	localparam logic [1:0] FUNC_MASK  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] key_code;
		logic       is_press;
		logic [7:0] mod_mask;
	} in_word_t;

	typedef struct packed {
		logic       handled;
		logic [7:0] modifier_byte;
		logic [7:0] slot_0;
		logic [7:0] slot_1;
		logic [7:0] slot_2;
		logic [7:0] slot_3;
		logic [7:0] slot_4;
		logic [7:0] slot_5;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic apply_simple;
		logic clr_idx;
		logic step_idx;
		logic resolve;
		logic shift;
	} dp_cmd_t;

	typedef struct packed {
		logic simple;
		logic hit;
		logic at_end;
		logic press;
	} dp_status_t;

endpackage

### rtl/core/hidkb_ctrl.sv
// Controller state machine of the HID keyboard report tracker.
module hidkb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  hidkb_pkg::dp_status_t status,
	output hidkb_pkg::dp_cmd_t    ctl,
	output logic                  busy,
	output logic                  done
);
	import hidkb_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_DECODE  = 6'b000010,
		ST_SEARCH  = 6'b000100,
		ST_RESOLVE = 6'b001000,
		ST_SHIFT   = 6'b010000,
		ST_DONE    = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.simple) begin
					ctl.apply_simple = 1'b1;
					state_d          = ST_DONE;
				end else begin
					ctl.clr_idx = 1'b1;
					state_d     = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (status.hit || status.at_end) begin
					state_d = ST_RESOLVE;
				end else begin
					ctl.step_idx = 1'b1;
				end
			end
			ST_RESOLVE: begin
				ctl.resolve = 1'b1;
				if (!status.press && status.hit) begin
					state_d = ST_SHIFT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SHIFT: begin
				ctl.shift = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

### rtl/core/hidkb_dp.sv
// Datapath of the HID keyboard report tracker: key table, modifiers, flags.
module hidkb_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hidkb_pkg::in_word_t   cmd,
	input  hidkb_pkg::dp_cmd_t    ctl,
	output hidkb_pkg::dp_status_t status,
	output hidkb_pkg::out_word_t  result
);
	import hidkb_pkg::*;

	in_word_t         item_q;
	logic [7:0]       key_q [TABLE_DEPTH];
	logic [7:0]       key_up [TABLE_DEPTH];
	logic [7:0]       slot_v [TABLE_DEPTH];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [7:0]       mod_q;
	logic             roll_q;
	logic             handled_q;
	logic             is_mod;
	logic             at_end;
	logic             hit;
	logic [7:0]       rd_key;
	logic [7:0]       mod_bit;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_up
		if (g < TABLE_DEPTH - 1) begin : g_mid
			assign key_up[g] = key_q[g+1];
		end else begin : g_last
			assign key_up[g] = '0;
		end
	end

	assign is_mod  = (item_q.key_code >= MOD_FIRST) && (item_q.key_code <= MOD_LAST);
	assign at_end  = (idx_q == cnt_q);
	assign rd_key  = at_end ? 8'h00 : key_q[idx_q];
	assign hit     = !at_end && (rd_key == item_q.key_code);
	assign mod_bit = 8'h01 << item_q.key_code[2:0];

	assign status.simple = (item_q.func != FUNC_KEY) || is_mod;
	assign status.hit    = hit;
	assign status.at_end = at_end;
	assign status.press  = item_q.is_press;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < TABLE_DEPTH; j++) begin
				key_q[j] <= '0;
			end
			cnt_q     <= '0;
			idx_q     <= '0;
			mod_q     <= '0;
			roll_q    <= 1'b0;
			handled_q <= 1'b0;
		end else begin
			if (ctl.apply_simple) begin
				case (item_q.func)
					FUNC_KEY: begin
						mod_q     <= item_q.is_press ? (mod_q | mod_bit) : (mod_q & ~mod_bit);
						handled_q <= 1'b1;
					end
					FUNC_MASK: begin
						mod_q     <= item_q.is_press ? (mod_q | item_q.mod_mask)
							: (mod_q & ~item_q.mod_mask);
						handled_q <= 1'b1;
					end
					FUNC_CLEAR: begin
						for (int j = 0; j < TABLE_DEPTH; j++) begin
							key_q[j] <= '0;
						end
						cnt_q     <= '0;
						mod_q     <= '0;
						roll_q    <= 1'b0;
						handled_q <= 1'b1;
					end
					default: begin
						handled_q <= 1'b0;
					end
				endcase
			end
			if (ctl.clr_idx) begin
				idx_q <= '0;
			end
			if (ctl.step_idx) begin
				idx_q <= idx_q + 1'b1;
			end
			if (ctl.resolve) begin
				if (item_q.is_press) begin
					if (hit) begin
						handled_q <= 1'b1;
					end else if (cnt_q < CNT_W'(SLOT_LIMIT)) begin
						key_q[cnt_q] <= item_q.key_code;
						cnt_q        <= cnt_q + 1'b1;
						handled_q    <= 1'b1;
					end else begin
						roll_q    <= 1'b1;
						handled_q <= 1'b0;
					end
				end else if (!hit) begin
					handled_q <= 1'b0;
				end
			end
			if (ctl.shift) begin
				for (int j = 0; j < TABLE_DEPTH; j++) begin
					if (CNT_W'(j) == CNT_W'(cnt_q - 1'b1)) begin
						key_q[j] <= '0;
					end else if (CNT_W'(j) >= idx_q && CNT_W'(j) < cnt_q) begin
						key_q[j] <= key_up[j];
					end
				end
				cnt_q     <= cnt_q - 1'b1;
				roll_q    <= 1'b0;
				handled_q <= 1'b1;
			end
		end
	end

	always_comb begin
		for (int j = 0; j < TABLE_DEPTH; j++) begin
			if (j < SLOT_LIMIT) begin
				slot_v[j] = roll_q ? ROLLOVER_CODE : key_q[j];
			end else begin
				slot_v[j] = '0;
			end
		end
	end

	assign result.handled       = handled_q;
	assign result.modifier_byte = mod_q;
	assign result.slot_0        = slot_v[0];
	assign result.slot_1        = slot_v[1];
	assign result.slot_2        = slot_v[2];
	assign result.slot_3        = slot_v[3];
	assign result.slot_4        = slot_v[4];
	assign result.slot_5        = slot_v[5];

endmodule

### rtl/core/hid_keyboard_report_tracker_top.sv
// Top level of the HID keyboard report tracker: controller plus datapath.
// Sequence: modifier, mask, clear and unknown words go from DECODE straight to DONE;
// key words go from DECODE to SEARCH, which scans one slot a cycle until a match or the key
// count is reached, then to RESOLVE, then to SHIFT when a release removes a key, then to DONE.
// Throughput: one word at a time; start is taken again the cycle after done.
// Reset: arst_n clears modifiers, key table, count and rollover; done cannot be stalled.
module hid_keyboard_report_tracker_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  hidkb_pkg::in_word_t  cmd,
	output logic                 busy,
	output logic                 done,
	output hidkb_pkg::out_word_t result
);
	import hidkb_pkg::*;

	dp_cmd_t    ctl;
	dp_status_t status;

	hidkb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	hidkb_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctl    (ctl),
		.status (status),
		.result (result)
	);

`ifndef NO_ASSERTIONS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done)) else $error("accepted word not in work");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		u_dp.cnt_q <= CNT_W'(SLOT_LIMIT)) else $error("key count beyond slot limit");
`endif

endmodule
